[rtl/balloc_pkg.sv]
// Shared constants, codes and types of the buddy allocator.
package balloc_pkg;

  localparam int NUM_ORDERS      = 11;
  localparam int MIN_BLOCK_BYTES = 64;
  localparam int HEADER_BYTES    = 8;

  localparam int TOP_ORDER = NUM_ORDERS - 1;
  localparam int LEAF_W    = NUM_ORDERS - 1;
  localparam int LEAVES    = 1 << LEAF_W;
  localparam int LINK_W    = LEAF_W + 1;
  localparam int OW        = $clog2(NUM_ORDERS);
  localparam int CW        = $clog2(NUM_ORDERS + 1);
  localparam int MIN_SHIFT = $clog2(MIN_BLOCK_BYTES);
  localparam int HDR_W     = OW + 16;
  localparam int SUM_W     = ((LEAF_W + MIN_SHIFT) > 16 ? (LEAF_W + MIN_SHIFT) : 16) + 2;

  localparam int CFG_W            = 4;
  localparam int RESET_HEAP_ORDER = 10;
  localparam int RESET_TOP        = (RESET_HEAP_ORDER > TOP_ORDER) ? TOP_ORDER
                                                                   : RESET_HEAP_ORDER;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [LEAF_W-1:0] leaf_t;
  typedef logic [OW-1:0]     ord_t;

  localparam link_t NIL = link_t'(LEAVES);

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_OFFSET  = 2'd3;

endpackage

[rtl/balloc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module balloc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/buddy_allocator_unit.sv]
// Buddy allocator top level: sequencer, free-list heads and leaf stores.
//
// One transaction at a time. A clear, a rejected allocate and a null or
// early-rejected free go from idle straight to the result state; a free whose
// header fails its checks ends after the header read. An allocate searches up
// through the empty orders above the request, then splits one block per order
// down to the request. An allocate that finds no free block ends after
// searching past the top order. A free merges with its buddy order by order
// and stops when the block reaches the top order, its buddy lies outside the
// heap or the buddy is not a free block of the same order. The sequencer walks
// the orders one per step with registered reads of the link, order and
// free-bit RAMs. After reset the block runs a clearing pass over the free-bit
// RAM, one leaf a cycle, before it accepts its first transaction; the
// configuration port is always ready. A finished result is held in the output
// register until taken, and the next result waits behind it.
module buddy_allocator_unit import balloc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  input  logic [15:0]      req_size_i,
  input  logic [15:0]      req_align_i,
  input  logic [15:0]      free_addr_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [15:0]      alloc_addr_o
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SRCH  = 4'd2;
  localparam logic [3:0] S_SPRD  = 4'd3;
  localparam logic [3:0] S_SPW1  = 4'd4;
  localparam logic [3:0] S_SPW2  = 4'd5;
  localparam logic [3:0] S_SPW3  = 4'd6;
  localparam logic [3:0] S_AFIN  = 4'd7;
  localparam logic [3:0] S_APOP  = 4'd8;
  localparam logic [3:0] S_FCHK  = 4'd9;
  localparam logic [3:0] S_MRD   = 4'd10;
  localparam logic [3:0] S_MCHK  = 4'd11;
  localparam logic [3:0] S_PSH1  = 4'd12;
  localparam logic [3:0] S_PSH2  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0]       state_q, state_d;
  logic [CFG_W-1:0] heap_order_q, heap_order_d;
  link_t            head_q [NUM_ORDERS];
  link_t            head_d [NUM_ORDERS];
  leaf_t            init_cnt_q, init_cnt_d;
  logic             out_valid_q, out_valid_d;

  logic [CW-1:0] c_q, c_d;
  ord_t          o_q, o_d;
  leaf_t         leaf_q, leaf_d;
  leaf_t         buddy_q, buddy_d;
  link_t         h_q, h_d;
  logic [15:0]   a_q, a_d;
  logic [15:0]   align_q, align_d;
  logic [15:0]   dat_q, dat_d;
  logic [15:0]   off_q, off_d;
  leaf_t         hl_q, hl_d;
  logic [1:0]    res_st_q, res_st_d;
  logic [15:0]   res_addr_q, res_addr_d;
  logic [1:0]    out_st_q, out_st_d;
  logic [15:0]   out_addr_q, out_addr_d;

  // RAM ports
  logic             nx_we, pv_we, bf_we, bo_we, hd_we;
  leaf_t            nx_wa, pv_wa, bf_wa, bo_wa, hd_wa;
  leaf_t            nx_ra, pv_ra, bf_ra, bo_ra, hd_ra;
  link_t            nx_wd, pv_wd, nx_rd, pv_rd;
  logic             bf_wd, bf_rd;
  ord_t             bo_wd, bo_rd;
  logic [HDR_W-1:0] hd_wd, hd_rd;

  balloc_ram #(.W(LINK_W), .D(LEAVES)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd), .raddr_i(nx_ra), .rdata_o(nx_rd)
  );
  balloc_ram #(.W(LINK_W), .D(LEAVES)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd), .raddr_i(pv_ra), .rdata_o(pv_rd)
  );
  balloc_ram #(.W(1), .D(LEAVES)) u_bfree (
    .clk_i, .we_i(bf_we), .waddr_i(bf_wa), .wdata_i(bf_wd), .raddr_i(bf_ra), .rdata_o(bf_rd)
  );
  balloc_ram #(.W(OW), .D(LEAVES)) u_bord (
    .clk_i, .we_i(bo_we), .waddr_i(bo_wa), .wdata_i(bo_wd), .raddr_i(bo_ra), .rdata_o(bo_rd)
  );
  balloc_ram #(.W(HDR_W), .D(LEAVES)) u_hdr (
    .clk_i, .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd), .raddr_i(hd_ra), .rdata_o(hd_rd)
  );

  // Combinational helpers
  ord_t          top;
  logic [17:0]   total;
  logic [CW-1:0] req_cnt;
  logic          req_bad;
  logic [15:0]   a_m, hl_full;
  ord_t          lo;
  leaf_t         sp_buddy, cur_leaf, m_buddy;
  logic [SUM_W-1:0] start, am1, dsum, off_w;
  ord_t          r_ord;
  logic [15:0]   r_off, s_w, leaf16, omask;

  assign top = (32'(heap_order_q) > TOP_ORDER) ? ord_t'(TOP_ORDER) : ord_t'(heap_order_q);

  always_comb begin
    total   = 18'(req_size_i) + 18'(req_align_i) + 18'(HEADER_BYTES);
    req_bad = (req_size_i == 16'd0) || (req_align_i == 16'd0) ||
              ((req_align_i & (req_align_i - 16'd1)) != 16'd0);
    req_cnt = '0;
    for (int k = 0; k < NUM_ORDERS; k++) begin
      if ((32'(MIN_BLOCK_BYTES) << k) < 32'(total)) req_cnt = req_cnt + CW'(1);
    end
  end

  assign a_m     = free_addr_i - 16'(HEADER_BYTES);
  assign hl_full = a_m >> MIN_SHIFT;

  assign lo       = ord_t'(c_q - CW'(1));
  assign sp_buddy = leaf_q ^ (leaf_t'(1) << lo);
  assign cur_leaf = head_q[o_q][LEAF_W-1:0];
  assign m_buddy  = leaf_q ^ (leaf_t'(1) << o_q);

  assign start = SUM_W'(cur_leaf) << MIN_SHIFT;
  assign am1   = SUM_W'(align_q) - SUM_W'(1);
  assign dsum  = (start + SUM_W'(HEADER_BYTES) + am1) & ~am1;
  assign off_w = dsum - start;

  assign r_ord  = hd_rd[HDR_W-1:16];
  assign r_off  = hd_rd[15:0];
  assign s_w    = a_q - r_off;
  assign leaf16 = s_w >> MIN_SHIFT;
  assign omask  = (16'd1 << r_ord) - 16'd1;

  always_comb begin
    state_d      = state_q;
    heap_order_d = heap_order_q;
    head_d       = head_q;
    init_cnt_d   = init_cnt_q;
    out_valid_d  = out_valid_q;
    c_d = c_q; o_d = o_q; leaf_d = leaf_q; buddy_d = buddy_q; h_d = h_q;
    a_d = a_q; align_d = align_q; dat_d = dat_q; off_d = off_q; hl_d = hl_q;
    res_st_d = res_st_q; res_addr_d = res_addr_q;
    out_st_d = out_st_q; out_addr_d = out_addr_q;
    nx_we = 1'b0; nx_wa = '0; nx_wd = NIL; nx_ra = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = NIL; pv_ra = '0;
    bf_we = 1'b0; bf_wa = '0; bf_wd = 1'b0; bf_ra = '0;
    bo_we = 1'b0; bo_wa = '0; bo_wd = '0; bo_ra = '0;
    hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;

    if (cfg_valid_i) heap_order_d = cfg_data_i;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_INIT: begin
        // sweep the free bits, leaving leaf 0 as the one free block
        bf_we = 1'b1;
        bf_wa = init_cnt_q;
        bf_wd = (init_cnt_q == '0);
        if (init_cnt_q == '0) begin
          bo_we = 1'b1; bo_wd = ord_t'(RESET_TOP);
          nx_we = 1'b1; pv_we = 1'b1;
        end
        init_cnt_d = init_cnt_q + leaf_t'(1);
        if (&init_cnt_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_addr_d = '0;
          state_d    = S_DONE;
          case (op_i)
            OP_ALLOC: begin
              align_d = req_align_i;
              if (req_bad) begin
                res_st_d = ST_BAD;
              end else if (32'(req_cnt) >= NUM_ORDERS) begin
                res_st_d = ST_NOSPACE;
              end else begin
                c_d     = req_cnt;
                o_d     = ord_t'(req_cnt);
                state_d = S_SRCH;
              end
            end
            OP_FREE: begin
              a_d = free_addr_i;
              if (free_addr_i == 16'd0) begin
                res_st_d = ST_OK;
              end else if (free_addr_i < 16'(HEADER_BYTES)) begin
                res_st_d = ST_BAD;
              end else if ((hl_full >> top) != 16'd0) begin
                res_st_d = ST_BAD;
              end else begin
                hd_ra   = hl_full[LEAF_W-1:0];
                state_d = S_FCHK;
              end
            end
            OP_CLEAR: begin
              for (int i = 0; i < NUM_ORDERS; i++) head_d[i] = NIL;
              head_d[top] = '0;
              bf_we = 1'b1; bf_wd = 1'b1;
              bo_we = 1'b1; bo_wd = top;
              nx_we = 1'b1; pv_we = 1'b1;
              res_st_d = ST_OK;
            end
            default: res_st_d = ST_BAD;
          endcase
        end
      end
      S_SRCH: begin
        if (32'(c_q) >= NUM_ORDERS) begin
          res_st_d = ST_NOSPACE;
          state_d  = S_DONE;
        end else if (!head_q[c_q[OW-1:0]][LEAF_W]) begin
          state_d = (c_q == CW'(o_q)) ? S_AFIN : S_SPRD;
        end else begin
          c_d = c_q + CW'(1);
        end
      end
      S_SPRD: begin
        leaf_d = head_q[c_q[OW-1:0]][LEAF_W-1:0];
        nx_ra  = head_q[c_q[OW-1:0]][LEAF_W-1:0];
        state_d = S_SPW1;
      end
      S_SPW1: begin
        // pop the block, then mark both halves free at the lower order
        head_d[c_q[OW-1:0]] = nx_rd[LEAF_W] ? NIL : nx_rd;
        if (!nx_rd[LEAF_W]) begin
          pv_we = 1'b1; pv_wa = nx_rd[LEAF_W-1:0]; pv_wd = NIL;
        end
        nx_we = 1'b1; nx_wa = sp_buddy; nx_wd = head_q[lo];
        bf_we = 1'b1; bf_wa = leaf_q; bf_wd = 1'b1;
        bo_we = 1'b1; bo_wa = leaf_q; bo_wd = lo;
        state_d = S_SPW2;
      end
      S_SPW2: begin
        pv_we = 1'b1; pv_wa = sp_buddy; pv_wd = link_t'(leaf_q);
        nx_we = 1'b1; nx_wa = leaf_q; nx_wd = link_t'(sp_buddy);
        bf_we = 1'b1; bf_wa = sp_buddy; bf_wd = 1'b1;
        bo_we = 1'b1; bo_wa = sp_buddy; bo_wd = lo;
        state_d = S_SPW3;
      end
      S_SPW3: begin
        pv_we = 1'b1; pv_wa = leaf_q; pv_wd = NIL;
        head_d[lo] = link_t'(leaf_q);
        c_d = c_q - CW'(1);
        state_d = (lo == o_q) ? S_AFIN : S_SPRD;
      end
      S_AFIN: begin
        leaf_d = cur_leaf;
        dat_d  = dsum[15:0];
        off_d  = off_w[15:0];
        hl_d   = leaf_t'((dsum - SUM_W'(HEADER_BYTES)) >> MIN_SHIFT);
        nx_ra  = cur_leaf;
        if (|off_w[SUM_W-1:16]) begin
          res_st_d = ST_OFFSET;
          state_d  = S_DONE;
        end else if (|dsum[SUM_W-1:16]) begin
          res_st_d = ST_NOSPACE;
          state_d  = S_DONE;
        end else begin
          state_d = S_APOP;
        end
      end
      S_APOP: begin
        head_d[o_q] = nx_rd[LEAF_W] ? NIL : nx_rd;
        if (!nx_rd[LEAF_W]) begin
          pv_we = 1'b1; pv_wa = nx_rd[LEAF_W-1:0]; pv_wd = NIL;
        end
        bf_we = 1'b1; bf_wa = leaf_q; bf_wd = 1'b0;
        hd_we = 1'b1; hd_wa = hl_q; hd_wd = {o_q, off_q};
        res_st_d   = ST_OK;
        res_addr_d = dat_q;
        state_d    = S_DONE;
      end
      S_FCHK: begin
        if ((r_off > a_q) || (s_w[MIN_SHIFT-1:0] != '0) || (r_ord > top) ||
            ((leaf16 >> top) != 16'd0) || ((leaf16 & omask) != 16'd0)) begin
          res_st_d = ST_BAD;
          state_d  = S_DONE;
        end else begin
          bf_we = 1'b1; bf_wa = leaf16[LEAF_W-1:0]; bf_wd = 1'b1;
          leaf_d  = leaf16[LEAF_W-1:0];
          o_d     = r_ord;
          state_d = S_MRD;
        end
      end
      S_MRD: begin
        buddy_d = m_buddy;
        bf_ra = m_buddy; bo_ra = m_buddy; nx_ra = m_buddy; pv_ra = m_buddy;
        if ((32'(o_q) >= TOP_ORDER) || ((m_buddy >> top) != '0)) state_d = S_PSH1;
        else state_d = S_MCHK;
      end
      S_MCHK: begin
        if (!bf_rd || (bo_rd != o_q)) begin
          state_d = S_PSH1;
        end else begin
          // unlink the buddy from its list and step up one order
          if (!pv_rd[LEAF_W]) begin
            nx_we = 1'b1; nx_wa = pv_rd[LEAF_W-1:0]; nx_wd = nx_rd;
          end
          if (!nx_rd[LEAF_W]) begin
            pv_we = 1'b1; pv_wa = nx_rd[LEAF_W-1:0]; pv_wd = pv_rd;
          end
          if (head_q[o_q] == link_t'(buddy_q)) head_d[o_q] = nx_rd[LEAF_W] ? NIL : nx_rd;
          if (buddy_q < leaf_q) leaf_d = buddy_q;
          o_d     = o_q + ord_t'(1);
          state_d = S_MRD;
        end
      end
      S_PSH1: begin
        h_d   = head_q[o_q];
        pv_we = 1'b1; pv_wa = leaf_q; pv_wd = NIL;
        nx_we = 1'b1; nx_wa = leaf_q; nx_wd = head_q[o_q];
        bf_we = 1'b1; bf_wa = leaf_q; bf_wd = 1'b1;
        bo_we = 1'b1; bo_wa = leaf_q; bo_wd = o_q;
        state_d = S_PSH2;
      end
      S_PSH2: begin
        if (!h_q[LEAF_W]) begin
          pv_we = 1'b1; pv_wa = h_q[LEAF_W-1:0]; pv_wd = link_t'(leaf_q);
        end
        head_d[o_q] = link_t'(leaf_q);
        res_st_d = ST_OK;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_addr_d  = res_addr_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      heap_order_q <= CFG_W'(RESET_HEAP_ORDER);
      init_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NUM_ORDERS; i++) head_q[i] <= (i == RESET_TOP) ? link_t'(0) : NIL;
    end else begin
      state_q      <= state_d;
      heap_order_q <= heap_order_d;
      init_cnt_q   <= init_cnt_d;
      out_valid_q  <= out_valid_d;
      head_q       <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d; o_q <= o_d; leaf_q <= leaf_d; buddy_q <= buddy_d; h_q <= h_d;
    a_q <= a_d; align_q <= align_d; dat_q <= dat_d; off_q <= off_d; hl_q <= hl_d;
    res_st_q <= res_st_d; res_addr_q <= res_addr_d;
    out_st_q <= out_st_d; out_addr_q <= out_addr_d;
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_st_q;
  assign alloc_addr_o = out_addr_q;

endmodule

[rtl/balloc_checker.sv]
// Port-level checks of the buddy allocator, bound to the top level.
module balloc_checker import balloc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [15:0] alloc_addr_o
);

  // one transaction in flight: no new accept right after one
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a transaction is in flight");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(alloc_addr_o)))
    else $error("stalled result changed");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (alloc_addr_o == 16'd0))
    else $error("failed transaction carries an address");

  a_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (alloc_addr_o != 16'd0)) |-> (alloc_addr_o >= 16'(HEADER_BYTES)))
    else $error("data address leaves no room for the header");

endmodule

bind buddy_allocator_unit balloc_checker u_balloc_checker (.*);
